// ===== design/fhmp_pkg.sv =====
// ----------------------------------------------------------------------------
// fhmp_pkg: frame header / metadata parser shared definitions
// Constants, status codes, register indexes and the config / result structs.
// ----------------------------------------------------------------------------
package fhmp_pkg;

    // Frame layout
    localparam int unsigned HEADER_BYTES = 14;
    localparam logic [7:0]  MAGIC_BYTE   = 8'h4B;
    localparam logic [2:0]  MAJOR_MASK   = 3'h7;
    localparam int unsigned MAJOR_SHIFT  = 5;

    // Result queue depth (at least two)
    localparam int unsigned QUEUE_DEPTH  = 4;

    // Result kinds
    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Summary status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
    localparam logic [2:0] ST_BAD_VER    = 3'd3;
    localparam logic [2:0] ST_SHORT_META = 3'd4;
    localparam logic [2:0] ST_CAPACITY   = 3'd5;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAJOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAG_BIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_BIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRI_BIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TS_BIT   = 3'd5;

    // Register reset values
    localparam logic [2:0]  RST_MAJOR    = 3'd1;
    localparam logic [15:0] RST_CAPACITY = 16'hFFFF;
    localparam logic [3:0]  RST_FRAG_BIT = 4'd0;
    localparam logic [3:0]  RST_ACK_BIT  = 4'd1;
    localparam logic [3:0]  RST_PRI_BIT  = 4'd2;
    localparam logic [3:0]  RST_TS_BIT   = 4'd3;

    typedef struct packed {
        logic [2:0]  major;
        logic [15:0] capacity;
        logic [3:0]  frag_bit;
        logic [3:0]  ack_bit;
        logic [3:0]  pri_bit;
        logic [3:0]  ts_bit;
    } t_cfg;

    typedef struct packed {
        logic        out_kind;
        logic [15:0] payload;
        logic [2:0]  status;
        logic [7:0]  channel_id;
        logic [7:0]  frame_kind;
        logic [7:0]  version_byte;
        logic [15:0] flag_word;
        logic [63:0] packet_number;
        logic [31:0] fragment_info;
        logic [63:0] ack_number;
        logic [7:0]  priority_level;
        logic [63:0] time_ms;
    } t_result;

endpackage

// ===== design/fhmp_parse.sv =====
// ----------------------------------------------------------------------------
// fhmp_parse: per-byte frame parser
// Holds the frame state, decodes one byte per fire and produces up to two
// result items (a body byte and/or the end-of-frame summary).
// ----------------------------------------------------------------------------
module fhmp_parse
    import fhmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_res0,
    output t_result    o_res1,
    output logic [1:0] o_push_cnt
);

    // Frame state
    logic [15:0] r_pos, n_pos;
    logic        r_bad_magic, n_bad_magic;
    logic        r_bad_ver, n_bad_ver;
    logic        r_excess, n_excess;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_channel, n_channel;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_flags, n_flags;
    logic [63:0] r_packet, n_packet;
    logic [31:0] r_frag, n_frag;
    logic [63:0] r_ack, n_ack;
    logic [7:0]  r_pri, n_pri;
    logic [63:0] r_time, n_time;
    logic [15:0] r_body_cnt, n_body_cnt;

    // Metadata layout from the presence flags
    logic        has_frag, has_ack, has_pri, has_ts;
    logic [4:0]  s_ack, s_pri, s_ts, meta_len;
    logic [15:0] rel, sum_rel;
    logic [4:0]  rel5;
    logic        body_emit;
    logic [2:0]  sum_status;
    t_result     body_res, sum_res;

    assign has_frag = r_flags[i_cfg.frag_bit];
    assign has_ack  = r_flags[i_cfg.ack_bit];
    assign has_pri  = r_flags[i_cfg.pri_bit];
    assign has_ts   = r_flags[i_cfg.ts_bit];

    assign s_ack    = has_frag ? 5'd4 : 5'd0;
    assign s_pri    = s_ack + (has_ack ? 5'd8 : 5'd0);
    assign s_ts     = s_pri + (has_pri ? 5'd1 : 5'd0);
    assign meta_len = s_ts + (has_ts ? 5'd8 : 5'd0);

    assign rel  = r_pos - 16'(HEADER_BYTES);
    assign rel5 = rel[4:0];

    // Byte decode and summary build
    always_comb begin
        n_pos      = r_pos;
        n_bad_magic = r_bad_magic;
        n_bad_ver  = r_bad_ver;
        n_excess   = r_excess;
        n_version  = r_version;
        n_channel  = r_channel;
        n_type     = r_type;
        n_flags    = r_flags;
        n_packet   = r_packet;
        n_frag     = r_frag;
        n_ack      = r_ack;
        n_pri      = r_pri;
        n_time     = r_time;
        n_body_cnt = r_body_cnt;
        body_emit  = 1'b0;
        o_res0     = '0;
        o_res1     = '0;
        o_push_cnt = 2'd0;
        sum_status = ST_OK;
        sum_res    = '0;
        sum_rel    = '0;

        body_res          = '0;
        body_res.out_kind = KIND_BODY;
        body_res.payload  = {8'd0, i_byte};

        if (i_fire) begin
            if (r_pos == 16'hFFFF) begin
                // frame too long: byte dropped
                n_excess = 1'b1;
            end else begin
                if (r_pos < 16'(HEADER_BYTES)) begin
                    case (r_pos[3:0]) inside
                        4'd0: n_bad_magic = (i_byte != MAGIC_BYTE);
                        4'd1: begin
                            n_version = i_byte;
                            n_bad_ver = ((i_byte[7:MAJOR_SHIFT] & MAJOR_MASK) != i_cfg.major);
                        end
                        4'd2: n_channel = i_byte;
                        4'd3: n_type    = i_byte;
                        4'd4, 4'd5: n_flags = {r_flags[7:0], i_byte};
                        default: n_packet = {r_packet[55:0], i_byte};
                    endcase
                end else if (rel < {11'd0, meta_len}) begin
                    // metadata in fixed order
                    if (has_frag && (rel5 < 5'd4)) begin
                        n_frag = {r_frag[23:0], i_byte};
                    end else if (has_ack && (rel5 < s_ack + 5'd8)) begin
                        n_ack = {r_ack[55:0], i_byte};
                    end else if (has_pri && (rel5 < s_pri + 5'd1)) begin
                        n_pri = i_byte;
                    end else if (has_ts) begin
                        n_time = {r_time[55:0], i_byte};
                    end
                end else begin
                    // body byte
                    body_emit  = !r_bad_magic && !r_bad_ver && (r_body_cnt < i_cfg.capacity);
                    n_body_cnt = r_body_cnt + 16'd1;
                end
                n_pos = r_pos + 16'd1;
            end

            if (body_emit) begin
                o_res0     = body_res;
                o_push_cnt = 2'd1;
            end

            if (i_last) begin
                // status in precedence order
                sum_rel = n_pos - 16'(HEADER_BYTES);
                if (n_pos < 16'(HEADER_BYTES)) begin
                    sum_status = ST_SHORT_HDR;
                end else if (n_bad_magic) begin
                    sum_status = ST_BAD_MAGIC;
                end else if (n_bad_ver) begin
                    sum_status = ST_BAD_VER;
                end else if (sum_rel < {11'd0, meta_len}) begin
                    sum_status = ST_SHORT_META;
                end else if (n_excess || (n_body_cnt > i_cfg.capacity)) begin
                    sum_status = ST_CAPACITY;
                end

                sum_res.out_kind = KIND_SUMMARY;
                sum_res.status   = sum_status;
                if (sum_status == ST_OK) begin
                    sum_res.payload        = n_body_cnt;
                    sum_res.channel_id     = n_channel;
                    sum_res.frame_kind     = n_type;
                    sum_res.version_byte   = n_version;
                    sum_res.flag_word      = n_flags;
                    sum_res.packet_number  = n_packet;
                    sum_res.fragment_info  = n_frag;
                    sum_res.ack_number     = n_ack;
                    sum_res.priority_level = n_pri;
                    sum_res.time_ms        = n_time;
                end

                if (body_emit) begin
                    o_res1     = sum_res;
                    o_push_cnt = 2'd2;
                end else begin
                    o_res0     = sum_res;
                    o_push_cnt = 2'd1;
                end

                // start the next frame clean
                n_pos       = '0;
                n_bad_magic = 1'b0;
                n_bad_ver   = 1'b0;
                n_excess    = 1'b0;
                n_version   = '0;
                n_channel   = '0;
                n_type      = '0;
                n_flags     = '0;
                n_packet    = '0;
                n_frag      = '0;
                n_ack       = '0;
                n_pri       = '0;
                n_time      = '0;
                n_body_cnt  = '0;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_bad_magic <= 1'b0;
            r_bad_ver   <= 1'b0;
            r_excess    <= 1'b0;
            r_version   <= '0;
            r_channel   <= '0;
            r_type      <= '0;
            r_flags     <= '0;
            r_packet    <= '0;
            r_frag      <= '0;
            r_ack       <= '0;
            r_pri       <= '0;
            r_time      <= '0;
            r_body_cnt  <= '0;
        end else begin
            r_pos       <= n_pos;
            r_bad_magic <= n_bad_magic;
            r_bad_ver   <= n_bad_ver;
            r_excess    <= n_excess;
            r_version   <= n_version;
            r_channel   <= n_channel;
            r_type      <= n_type;
            r_flags     <= n_flags;
            r_packet    <= n_packet;
            r_frag      <= n_frag;
            r_ack       <= n_ack;
            r_pri       <= n_pri;
            r_time      <= n_time;
            r_body_cnt  <= n_body_cnt;
        end
    end

endmodule

// ===== design/fhmp_outq.sv =====
// ----------------------------------------------------------------------------
// fhmp_outq: result queue
// Takes up to two result items per cycle, hands out one per cycle on a
// valid/stall output. Reports room when two more items fit.
// ----------------------------------------------------------------------------
module fhmp_outq
    import fhmp_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_result        r_mem [DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_count, n_count;
    logic [PW-1:0]  wp1;
    logic           pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wp1     = ptr_inc(r_wp);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_count <= CW'(DEPTH - 2));

    // Pointer and count update
    always_comb begin
        n_wp    = r_wp;
        n_rp    = pop ? ptr_inc(r_rp) : r_rp;
        n_count = r_count + CW'(i_push_cnt) - CW'(pop);
        case (i_push_cnt)
            2'd1:    n_wp = wp1;
            2'd2:    n_wp = ptr_inc(wp1);
            default: n_wp = r_wp;
        endcase
    end

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wp1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/frame_header_metadata_parser.sv =====
// ----------------------------------------------------------------------------
// frame_header_metadata_parser: byte-serial frame header and metadata parser
// Checks the 14-byte header, captures header and optional metadata fields,
// passes body bytes and closes each frame with a summary item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  input    | in        | i_valid / o_stall  | i_rx_byte, i_frame_end
//  result   | out       | o_valid / i_stall  | o_out_kind ... o_time_ms
//  config   | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One byte per cycle while the input is not stalled. A byte is registered on
// accept, parsed into the result queue once it has room and handed out from
// there. A frame-end byte that also carries body yields two items, which leave
// one at a time on the single output port; the input stalls while a byte is
// held and the queue has fewer than two free entries. Reset is synchronous and
// empties the queue and the frame state; registers return to their defaults.
// ----------------------------------------------------------------------------
module frame_header_metadata_parser
    import fhmp_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_frame_end,
    // result items
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_out_kind,
    output logic [15:0]           o_payload,
    output logic [2:0]            o_status,
    output logic [7:0]            o_channel_id,
    output logic [7:0]            o_frame_kind,
    output logic [7:0]            o_version_byte,
    output logic [15:0]           o_flag_word,
    output logic [63:0]           o_packet_number,
    output logic [31:0]           o_fragment_info,
    output logic [63:0]           o_ack_number,
    output logic [7:0]            o_priority_level,
    output logic [63:0]           o_time_ms,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       room;
    logic       fire;
    logic       in_take;
    t_result    res0, res1, head;
    logic [1:0] push_cnt;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.major    <= RST_MAJOR;
            r_cfg.capacity <= RST_CAPACITY;
            r_cfg.frag_bit <= RST_FRAG_BIT;
            r_cfg.ack_bit  <= RST_ACK_BIT;
            r_cfg.pri_bit  <= RST_PRI_BIT;
            r_cfg.ts_bit   <= RST_TS_BIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAJOR:    r_cfg.major    <= i_cfg_data[2:0];
                CFG_CAPACITY: r_cfg.capacity <= i_cfg_data[15:0];
                CFG_FRAG_BIT: r_cfg.frag_bit <= i_cfg_data[3:0];
                CFG_ACK_BIT:  r_cfg.ack_bit  <= i_cfg_data[3:0];
                CFG_PRI_BIT:  r_cfg.pri_bit  <= i_cfg_data[3:0];
                CFG_TS_BIT:   r_cfg.ts_bit   <= i_cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    // Input register: parse fires when the queue can take two items
    assign fire    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
            r_in_last <= i_frame_end;
        end
    end

    fhmp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_fire     (fire),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .o_res0     (res0),
        .o_res1     (res1),
        .o_push_cnt (push_cnt)
    );

    fhmp_outq #(
        .DEPTH (QDEPTH)
    ) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_room     (room),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_head     (head)
    );

    // Result fields
    assign o_out_kind       = head.out_kind;
    assign o_payload        = head.payload;
    assign o_status         = head.status;
    assign o_channel_id     = head.channel_id;
    assign o_frame_kind     = head.frame_kind;
    assign o_version_byte   = head.version_byte;
    assign o_flag_word      = head.flag_word;
    assign o_packet_number  = head.packet_number;
    assign o_fragment_info  = head.fragment_info;
    assign o_ack_number     = head.ack_number;
    assign o_priority_level = head.priority_level;
    assign o_time_ms        = head.time_ms;

endmodule

// ===== verif/fhmp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhmp_checker: result scoreboard for the frame header / metadata parser
// Follows register writes, parses every accepted byte on its own copy of the
// frame state, queues the body and summary items that byte must produce and
// compares each accepted result item field by field against the oldest one.
// ----------------------------------------------------------------------------
module fhmp_checker
    import fhmp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel, as seen by the block
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_frame_end,
    // result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_result               i_result,
    // register writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // status towards the testbench top
    output int                    o_outstanding,
    output int                    o_checked,
    output int                    o_errors
);

    localparam int MAX_REPORTS = 40;

    // register copy
    t_cfg        regs;

    // frame state
    logic [15:0] pos_cnt;
    logic [15:0] body_cnt;
    logic        magic_bad;
    logic        ver_bad;
    logic        overlong;
    logic [7:0]  hdr_ver;
    logic [7:0]  hdr_chan;
    logic [7:0]  hdr_type;
    logic [15:0] hdr_flags;
    logic [63:0] hdr_packet;
    logic [31:0] meta_frag;
    logic [63:0] meta_ack;
    logic [7:0]  meta_prio;
    logic [63:0] meta_time;

    t_result     expected_items[$];
    t_result     oldest;

    task automatic clear_frame();
        pos_cnt    = '0;
        body_cnt   = '0;
        magic_bad  = 1'b0;
        ver_bad    = 1'b0;
        overlong   = 1'b0;
        hdr_ver    = '0;
        hdr_chan   = '0;
        hdr_type   = '0;
        hdr_flags  = '0;
        hdr_packet = '0;
        meta_frag  = '0;
        meta_ack   = '0;
        meta_prio  = '0;
        meta_time  = '0;
    endtask

    // metadata block length announced by the captured flags
    function automatic int unsigned meta_bytes();
        int unsigned n;
        n = 0;
        if (hdr_flags[regs.frag_bit]) n += 4;
        if (hdr_flags[regs.ack_bit])  n += 8;
        if (hdr_flags[regs.pri_bit])  n += 1;
        if (hdr_flags[regs.ts_bit])   n += 8;
        return n;
    endfunction

    // route one metadata byte to its field; shared flag bits keep fixed order
    task automatic store_meta(input int unsigned rel, input logic [7:0] b);
        int unsigned start;
        start = 0;
        if (hdr_flags[regs.frag_bit]) begin
            if (rel < start + 4) begin
                meta_frag = {meta_frag[23:0], b};
                return;
            end
            start += 4;
        end
        if (hdr_flags[regs.ack_bit]) begin
            if (rel < start + 8) begin
                meta_ack = {meta_ack[55:0], b};
                return;
            end
            start += 8;
        end
        if (hdr_flags[regs.pri_bit]) begin
            if (rel < start + 1) begin
                meta_prio = b;
                return;
            end
            start += 1;
        end
        if (hdr_flags[regs.ts_bit] && rel < start + 8) begin
            meta_time = {meta_time[55:0], b};
        end
    endtask

    // predict the items caused by one accepted byte
    task automatic parse_byte(input logic [7:0] b, input logic is_last);
        t_result     item;
        int unsigned rel;
        item = '0;
        if (pos_cnt == 16'hFFFF) begin
            // frame past 65535 bytes: byte dropped
            overlong = 1'b1;
        end else begin
            if (pos_cnt < HEADER_BYTES) begin
                case (pos_cnt)
                    16'd0: magic_bad = (b != MAGIC_BYTE);
                    16'd1: begin
                        hdr_ver = b;
                        ver_bad = (((b >> MAJOR_SHIFT) & 8'(MAJOR_MASK)) != 8'(regs.major));
                    end
                    16'd2: hdr_chan = b;
                    16'd3: hdr_type = b;
                    16'd4, 16'd5: hdr_flags = {hdr_flags[7:0], b};
                    default: hdr_packet = {hdr_packet[55:0], b};
                endcase
            end else begin
                rel = 32'(pos_cnt) - HEADER_BYTES;
                if (rel < meta_bytes()) begin
                    store_meta(rel, b);
                end else begin
                    if (!magic_bad && !ver_bad && body_cnt < regs.capacity) begin
                        item.out_kind = KIND_BODY;
                        item.payload  = {8'h00, b};
                        expected_items.push_back(item);
                    end
                    body_cnt = body_cnt + 16'd1;
                end
            end
            pos_cnt = pos_cnt + 16'd1;
        end

        // end-of-frame summary, errors in precedence order
        if (is_last) begin
            item = '0;
            item.out_kind = KIND_SUMMARY;
            if (pos_cnt < HEADER_BYTES) begin
                item.status = ST_SHORT_HDR;
            end else if (magic_bad) begin
                item.status = ST_BAD_MAGIC;
            end else if (ver_bad) begin
                item.status = ST_BAD_VER;
            end else if (32'(pos_cnt) - HEADER_BYTES < meta_bytes()) begin
                item.status = ST_SHORT_META;
            end else if (overlong || body_cnt > regs.capacity) begin
                item.status = ST_CAPACITY;
            end else begin
                item.status         = ST_OK;
                item.payload        = body_cnt;
                item.channel_id     = hdr_chan;
                item.frame_kind     = hdr_type;
                item.version_byte   = hdr_ver;
                item.flag_word      = hdr_flags;
                item.packet_number  = hdr_packet;
                item.fragment_info  = meta_frag;
                item.ack_number     = meta_ack;
                item.priority_level = meta_prio;
                item.time_ms        = meta_time;
            end
            expected_items.push_back(item);
            clear_frame();
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            if (o_errors < MAX_REPORTS)
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
            o_errors++;
        end
    endtask

    // all sampling at the rising edge; outputs settle before it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = '{major: RST_MAJOR, capacity: RST_CAPACITY, frag_bit: RST_FRAG_BIT,
                     ack_bit: RST_ACK_BIT, pri_bit: RST_PRI_BIT, ts_bit: RST_TS_BIT};
            clear_frame();
            expected_items.delete();
            o_checked = 0;
            o_errors  = 0;
        end else begin
            // result side
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_items.size() == 0) begin
                    if (o_errors < MAX_REPORTS)
                        $error("result item with nothing pending: kind %0d payload %0h status %0d",
                               i_result.out_kind, i_result.payload, i_result.status);
                    o_errors++;
                end else begin
                    oldest = expected_items.pop_front();
                    compare_field("out_kind", oldest.out_kind, i_result.out_kind);
                    compare_field("payload", oldest.payload, i_result.payload);
                    compare_field("status", oldest.status, i_result.status);
                    compare_field("channel_id", oldest.channel_id, i_result.channel_id);
                    compare_field("frame_kind", oldest.frame_kind, i_result.frame_kind);
                    compare_field("version_byte", oldest.version_byte, i_result.version_byte);
                    compare_field("flag_word", oldest.flag_word, i_result.flag_word);
                    compare_field("packet_number", oldest.packet_number,
                                  i_result.packet_number);
                    compare_field("fragment_info", oldest.fragment_info,
                                  i_result.fragment_info);
                    compare_field("ack_number", oldest.ack_number, i_result.ack_number);
                    compare_field("priority_level", oldest.priority_level,
                                  i_result.priority_level);
                    compare_field("time_ms", oldest.time_ms, i_result.time_ms);
                    o_checked++;
                end
            end

            // input side
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0)
                parse_byte(i_rx_byte, i_frame_end);

            // register writes count from the next byte on
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAJOR:    regs.major    = i_cfg_data[2:0];
                    CFG_CAPACITY: regs.capacity = i_cfg_data[15:0];
                    CFG_FRAG_BIT: regs.frag_bit = i_cfg_data[3:0];
                    CFG_ACK_BIT:  regs.ack_bit  = i_cfg_data[3:0];
                    CFG_PRI_BIT:  regs.pri_bit  = i_cfg_data[3:0];
                    CFG_TS_BIT:   regs.ts_bit   = i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
        o_outstanding = expected_items.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: frame header / metadata parser testbench
// Drives directed frames, then well-formed, truncated, corrupted and noise
// frames under several register settings, with random idling on both
// channels; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb;
    import fhmp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned PHASE_BYTES = 190;

    localparam t_cfg DEFAULT_CFG = '{major: RST_MAJOR, capacity: RST_CAPACITY,
                                     frag_bit: RST_FRAG_BIT, ack_bit: RST_ACK_BIT,
                                     pri_bit: RST_PRI_BIT, ts_bit: RST_TS_BIT};

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte   = 8'h00;
    logic                  frame_end = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_MAJOR;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic        out_kind;
    logic [15:0] payload;
    logic [2:0]  status;
    logic [7:0]  channel_id;
    logic [7:0]  frame_kind;
    logic [7:0]  version_byte;
    logic [15:0] flag_word;
    logic [63:0] packet_number;
    logic [31:0] fragment_info;
    logic [63:0] ack_number;
    logic [7:0]  priority_level;
    logic [63:0] time_ms;
    t_result     seen;

    int          outstanding;
    int          checked;
    int          errors;

    // stimulus control
    t_cfg        cur_cfg     = DEFAULT_CFG;
    int unsigned gap_pct     = 0;
    int unsigned stall_pct   = 0;
    logic        hold_req    = 1'b0;
    int unsigned bytes_sent  = 0;
    int unsigned frames_sent = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  frame_bytes[$];

    assign seen = {out_kind, payload, status, channel_id, frame_kind, version_byte,
                   flag_word, packet_number, fragment_info, ack_number,
                   priority_level, time_ms};

    frame_header_metadata_parser u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_rx_byte       (rx_byte),
        .i_frame_end     (frame_end),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_out_kind      (out_kind),
        .o_payload       (payload),
        .o_status        (status),
        .o_channel_id    (channel_id),
        .o_frame_kind    (frame_kind),
        .o_version_byte  (version_byte),
        .o_flag_word     (flag_word),
        .o_packet_number (packet_number),
        .o_fragment_info (fragment_info),
        .o_ack_number    (ack_number),
        .o_priority_level(priority_level),
        .o_time_ms       (time_ms),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    fhmp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_rx_byte    (rx_byte),
        .i_frame_end  (frame_end),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_result     (seen),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_outstanding(outstanding),
        .o_checked    (checked),
        .o_errors     (errors)
    );

    // 2 ns clock
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped at %0d cycles, %0d results still pending",
                 cycle_count, outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin : result_sink
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // metadata length the current flag-bit registers imply
    function automatic int unsigned meta_size(input logic [15:0] flags);
        int unsigned n;
        n = 0;
        if (flags[cur_cfg.frag_bit]) n += 4;
        if (flags[cur_cfg.ack_bit])  n += 8;
        if (flags[cur_cfg.pri_bit])  n += 1;
        if (flags[cur_cfg.ts_bit])   n += 8;
        return n;
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.major = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 4))
            0:       c.capacity = 16'd0;
            1:       c.capacity = 16'hFFFF;
            2:       c.capacity = 16'd1;
            default: c.capacity = 16'($urandom_range(2, 24));
        endcase
        c.frag_bit = 4'($urandom_range(0, 15));
        c.ack_bit  = 4'($urandom_range(0, 15));
        c.pri_bit  = 4'($urandom_range(0, 15));
        c.ts_bit   = 4'($urandom_range(0, 15));
        return c;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        frame_end <= is_last;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(frame_bytes[i], i == n - 1);
        frame_bytes.delete();
        frames_sent++;
    endtask

    task automatic put_header(input logic [7:0] magic, input logic [7:0] ver,
                              input logic [7:0] chan, input logic [7:0] ftype,
                              input logic [15:0] flags, input logic [63:0] packet);
        frame_bytes.push_back(magic);
        frame_bytes.push_back(ver);
        frame_bytes.push_back(chan);
        frame_bytes.push_back(ftype);
        frame_bytes.push_back(flags[15:8]);
        frame_bytes.push_back(flags[7:0]);
        for (int i = 7; i >= 0; i--)
            frame_bytes.push_back(packet[8*i +: 8]);
    endtask

    task automatic put_random(input int unsigned n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endtask

    // idle the input, wait out every pending result, then the pipeline depth
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_cfg(input t_cfg c);
        write_reg(CFG_MAJOR, 16'(c.major));
        write_reg(CFG_CAPACITY, c.capacity);
        write_reg(CFG_FRAG_BIT, 16'(c.frag_bit));
        write_reg(CFG_ACK_BIT, 16'(c.ack_bit));
        write_reg(CFG_PRI_BIT, 16'(c.pri_bit));
        write_reg(CFG_TS_BIT, 16'(c.ts_bit));
        cur_cfg = c;
    endtask

    // mostly well-formed frames, some cut short, corrupted or pure noise
    task automatic random_frame();
        int unsigned shape;
        int unsigned meta;
        int unsigned cut;
        logic [15:0] flags;
        logic [7:0]  magic;
        logic [7:0]  ver;
        shape = $urandom_range(0, 99);
        flags = 16'($urandom);
        if ($urandom_range(0, 1)) flags = flags & 16'($urandom);
        meta  = meta_size(flags);
        magic = MAGIC_BYTE;
        ver   = {cur_cfg.major, 5'($urandom)};
        if (shape >= 85 && shape < 93) begin
            if ($urandom_range(0, 1)) begin
                magic = 8'($urandom);
                if (magic == MAGIC_BYTE) magic = ~magic;
            end else begin
                ver[7:5] = cur_cfg.major ^ 3'($urandom_range(1, 7));
            end
        end
        if (shape >= 93) begin
            put_random($urandom_range(1, 30));
        end else begin
            put_header(magic, ver, 8'($urandom), 8'($urandom), flags, {$urandom, $urandom});
            put_random(meta);
            if ($urandom_range(0, 9) == 0) put_random($urandom_range(13, 60));
            else put_random($urandom_range(0, 12));
            // truncated: ends in the header or the metadata, at the latest where the metadata ends
            if (shape >= 75 && shape < 85) begin
                cut = $urandom_range(1, HEADER_BYTES + meta);
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
        end
        send_frame();
    endtask

    task automatic random_phase(input int unsigned n_bytes);
        int unsigned stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) random_frame();
        wait_drain();
    endtask

    initial begin : stimulus
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames on the reset register values
        // single byte: short header
        frame_bytes.push_back(MAGIC_BYTE);
        send_frame();
        // header only, extreme field values, no metadata bits set
        put_header(MAGIC_BYTE, 8'h3F, 8'hFF, 8'h00, 16'hFFF0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame();
        // bad magic and bad version together: magic wins
        put_header(8'h00, 8'hE0, 8'h00, 8'hFF, 16'h0000, 64'h0);
        put_random(2);
        send_frame();
        // bad version only, body bytes suppressed
        put_header(MAGIC_BYTE, 8'h00, 8'h12, 8'h34, 16'h0000, 64'h1);
        put_random(2);
        send_frame();
        // every metadata item present, body at byte extremes
        put_header(MAGIC_BYTE, 8'h20, 8'h81, 8'h7E, 16'h000F, 64'h8000_0000_0000_0001);
        put_random(21);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'hA5);
        send_frame();
        // timestamp announced but cut short: short metadata
        put_header(MAGIC_BYTE, 8'h21, 8'h01, 8'h02, 16'h0008, 64'h0);
        put_random(3);
        send_frame();
        wait_drain();

        // defaults, with a long result-side hold-off while bytes keep coming
        gap_pct   = 10;
        stall_pct = 10;
        apply_cfg(DEFAULT_CFG);
        hold_req = 1'b1;
        put_header(MAGIC_BYTE, 8'h25, 8'h10, 8'h20, 16'h0000, 64'h42);
        put_random(50);
        send_frame();
        random_phase(PHASE_BYTES);

        // zero capacity, all metadata on one shared flag bit
        gap_pct   = 25;
        stall_pct = 25;
        apply_cfg('{major: 3'd0, capacity: 16'd0, frag_bit: 4'd15, ack_bit: 4'd15,
                    pri_bit: 4'd15, ts_bit: 4'd15});
        random_phase(PHASE_BYTES);

        // top major version, tiny capacity, scattered flag bits, no idling
        gap_pct   = 0;
        stall_pct = 0;
        apply_cfg('{major: 3'd7, capacity: 16'd3, frag_bit: 4'd4, ack_bit: 4'd9,
                    pri_bit: 4'd12, ts_bit: 4'd15});
        random_phase(PHASE_BYTES);

        // random setting, heavy result-side stalls
        gap_pct   = 15;
        stall_pct = 30;
        apply_cfg(random_cfg());
        random_phase(PHASE_BYTES);

        // closing stretch with no idling
        gap_pct   = 0;
        stall_pct = 0;
        apply_cfg(random_cfg());
        random_phase(PHASE_BYTES);

        $display("Covered %0d frames and %0d input bytes: good, short, corrupt and noise",
                 frames_sent, bytes_sent);
        $display("frames under several register settings; %0d result items compared.",
                 checked);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== frame_header_metadata_parser.f =====
design/fhmp_pkg.sv
design/fhmp_parse.sv
design/fhmp_outq.sv
design/frame_header_metadata_parser.sv
verif/fhmp_checker.sv
verif/tb.sv
